[rtl/core/sdc_pkg.sv]
// shared types and constants of the sliding window distinct counter
package sdc_pkg;

    // width of the window length register as written on the config channel
    localparam int CFG_W = 7;

    // action applied to one frequency entry
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_DEC
    } op_kind_t;

    // one read-modify-write request to the frequency memory
    typedef struct packed {
        logic     valid;
        op_kind_t kind;
        logic     last;
        logic     emit;
    } op_ctl_t;

    // outcome of one request once it leaves the modify stage
    typedef struct packed {
        logic valid;
        logic rise;
        logic fall;
        logic last;
        logic emit;
    } freq_evt_t;

    // issue phase of the front end
    typedef enum logic {
        PH_ACCEPT,
        PH_LEAVE
    } phase_t;

endpackage

[rtl/core/sdc_freq_unit.sv]
// frequency memory with read-modify-write pipeline, forwarding and clearing sweep
module sdc_freq_unit #(
    parameter int VALUE_BITS = 10,
    parameter int CNT_W      = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdc_pkg::op_ctl_t      op,
    input  logic [VALUE_BITS-1:0] op_addr,
    input  logic                  clr_start,
    output sdc_pkg::freq_evt_t    evt,
    output logic                  clr_busy
);
    import sdc_pkg::*;

    localparam int DEPTH = 1 << VALUE_BITS;

    logic [CNT_W-1:0]      freq_mem [DEPTH];
    logic [CNT_W-1:0]      rd_data_reg;
    op_ctl_t               m_op_reg;
    logic [VALUE_BITS-1:0] m_addr_reg;
    logic                  fwd_hit_reg;
    logic [CNT_W-1:0]      fwd_data_reg;
    logic                  clr_active_reg;
    logic [VALUE_BITS-1:0] clr_addr_reg;

    logic [CNT_W-1:0]      cur;
    logic [CNT_W-1:0]      new_val;
    logic                  m_we;

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            rd_data_reg <= freq_mem[op_addr];
        end
    end

    // write port: clearing sweep or modify stage
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            freq_mem[clr_addr_reg] <= '0;
        end
        else if (m_we)
        begin
            freq_mem[m_addr_reg] <= new_val;
        end
    end

    // modify stage, the previous write is forwarded when it hits the same entry
    always_comb
    begin
        cur  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        m_we = m_op_reg.valid && (m_op_reg.kind != OP_NONE);
        unique case (m_op_reg.kind)
            OP_INC:  new_val = cur + CNT_W'(1);
            OP_DEC:  new_val = (cur != '0) ? cur - CNT_W'(1) : cur;
            default: new_val = cur;
        endcase
    end

    assign evt.valid = m_op_reg.valid;
    assign evt.rise  = m_op_reg.valid && (m_op_reg.kind == OP_INC) && (cur == '0);
    assign evt.fall  = m_op_reg.valid && (m_op_reg.kind == OP_DEC) && (cur == CNT_W'(1));
    assign evt.last  = m_op_reg.last;
    assign evt.emit  = m_op_reg.emit;
    assign clr_busy  = clr_active_reg;

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_op_reg    <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            m_op_reg    <= op;
            fwd_hit_reg <= m_we && op.valid && (m_addr_reg == op_addr);
        end
    end

    // payload of the stage
    always_ff @(posedge clk)
    begin
        m_addr_reg   <= op_addr;
        fwd_data_reg <= new_val;
    end

    // clearing sweep after reset and on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_start)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + VALUE_BITS'(1);
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/sliding_window_distinct_count.sv]
// Sliding window distinct counter: each transaction on s_* brings one value; after
// the window (window_len, 1..WINDOW_MAX, written on cfg_*) has filled, every
// transaction yields on m_* the number of distinct values among the last window_len
// values. The frequency memory (one read and one write port) does per item one
// read-modify-write for the entering value and one for the leaving value; the
// result enters the output buffer as the leaving request exits the modify stage.
// cfg_ready is low while an item is being processed, so a config write always
// lands between items. After reset and every config write a sweep clears all
// 2^VALUE_BITS (1024 by default) frequency entries, while s_tready stays low.
module sliding_window_distinct_count #(
    parameter int WINDOW_MAX = 64,
    parameter int VALUE_BITS = 10
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [sdc_pkg::CFG_W-1:0]                 cfg_data,   // window_len
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]           s_tdata,    // value
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [(($clog2(WINDOW_MAX+1)+7)/8)*8-1:0] m_tdata     // distinct_count
);
    import sdc_pkg::*;

    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int POS_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W     = $clog2(WINDOW_MAX + 2);
    localparam int OUT_TW    = ((LEN_W + 7) / 8) * 8;
    localparam int LEN_RESET = (WINDOW_MAX < 4) ? WINDOW_MAX : 4;

    logic [VALUE_BITS-1:0] wv_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] wv_rd_reg;

    logic [LEN_W-1:0]      len_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      seen_reg;
    logic [CNT_W-1:0]      distinct_reg;
    logic [CNT_W-1:0]      distinct_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  full_reg;
    logic                  emit_reg;
    logic                  inflight_reg;

    logic [LEN_W-1:0]      fifo_data_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            fifo_cnt_reg;

    logic [VALUE_BITS-1:0] value;
    logic                  accept;
    logic                  cfg_fire;
    logic                  room;
    logic                  full_now;
    logic [LEN_W-1:0]      seen_next;
    logic [LEN_W-1:0]      pos_inc;
    logic [LEN_W-1:0]      cfg_len;
    op_ctl_t               op;
    logic [VALUE_BITS-1:0] op_addr;
    freq_evt_t             evt;
    logic                  clr_busy;
    logic                  done;
    logic                  push;
    logic                  pop;

    sdc_freq_unit #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_freq (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .op_addr   (op_addr),
        .clr_start (cfg_fire),
        .evt       (evt),
        .clr_busy  (clr_busy)
    );

    // input side
    assign value     = s_tdata[VALUE_BITS-1:0];
    assign room      = (fifo_cnt_reg + {1'b0, inflight_reg}) < 2'd2;
    assign s_tready  = (phase_reg == PH_ACCEPT) && !clr_busy && !cfg_valid && room;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = !inflight_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // window bookkeeping for the item being taken
    always_comb
    begin
        full_now  = (seen_reg >= len_reg);
        seen_next = full_now ? seen_reg : seen_reg + LEN_W'(1);
        pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
        if (cfg_data == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (32'(cfg_data) > WINDOW_MAX)
        begin
            cfg_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            cfg_len = LEN_W'(cfg_data);
        end
    end

    // delay line, the old entry is read as the new one is written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wv_rd_reg       <= wv_mem[pos_reg];
            wv_mem[pos_reg] <= value;
        end
    end

    // issue phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACCEPT;
        end
        else if (cfg_fire)
        begin
            phase_reg <= PH_ACCEPT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // next phase and the request to the frequency memory
    always_comb
    begin
        phase_next = phase_reg;
        op         = '0;
        op_addr    = value;
        unique case (phase_reg)
            PH_ACCEPT:
            begin
                op.valid = accept;
                op.kind  = OP_INC;
                if (accept)
                begin
                    phase_next = PH_LEAVE;
                end
            end
            PH_LEAVE:
            begin
                op.valid   = 1'b1;
                op.kind    = full_reg ? OP_DEC : OP_NONE;
                op.last    = 1'b1;
                op.emit    = emit_reg;
                op_addr    = wv_rd_reg;
                phase_next = PH_ACCEPT;
            end
            default:
            begin
                phase_next = PH_ACCEPT;
            end
        endcase
    end

    // distinct total follows every frequency change
    always_comb
    begin
        distinct_next = distinct_reg;
        if (evt.rise)
        begin
            distinct_next = distinct_reg + CNT_W'(1);
        end
        else if (evt.fall && (distinct_reg != '0))
        begin
            distinct_next = distinct_reg - CNT_W'(1);
        end
    end

    assign done = evt.valid && evt.last;
    assign push = done && evt.emit;
    assign pop  = m_tvalid && m_tready;

    // window state and running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(LEN_RESET);
            pos_reg      <= '0;
            seen_reg     <= '0;
            distinct_reg <= '0;
            full_reg     <= 1'b0;
            emit_reg     <= 1'b0;
            inflight_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            len_reg      <= cfg_len;
            pos_reg      <= '0;
            seen_reg     <= '0;
            distinct_reg <= '0;
            full_reg     <= 1'b0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            distinct_reg <= distinct_next;
            if (accept)
            begin
                full_reg <= full_now;
                emit_reg <= (seen_next >= len_reg);
                seen_reg <= seen_next;
                pos_reg  <= (pos_inc >= len_reg) ? '0 : pos_inc[POS_W-1:0];
            end
            if (accept != done)
            begin
                inflight_reg <= accept;
            end
        end
    end

    // output buffer, two entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_data_reg[wr_ptr_reg] <= LEN_W'(distinct_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = OUT_TW'(fifo_data_reg[rd_ptr_reg]);

    // no item is taken while the frequency memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_tready)
        else $error("item accepted during clearing sweep");

    // a finished item always finds room in the output buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg != 2'd2) || pop)
        else $error("output buffer overflow");

    // completion only for an item that was taken
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> inflight_reg)
        else $error("item completed with none in flight");

    // a full window always holds at least one distinct value
    a_nonzero_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (distinct_next != '0))
        else $error("zero distinct count delivered");

endmodule
